[hdl/rsh_pkg.sv]
`default_nettype none

package rsh_pkg;

    // Geometry and widths
    localparam int PIXEL_BITS = 8;
    localparam int MAX_COLS   = 1024;
    localparam int ROW_LIMIT  = 1024;
    localparam int COL_BITS   = $clog2(MAX_COLS);
    localparam int DIM_BITS   = 11;
    localparam int GAIN_BITS  = 12;
    localparam int OUT_BITS   = 14;
    localparam int PIX_BITS   = 3 * PIXEL_BITS;
    localparam int NUM_LANES  = 3;
    localparam int WIN_TAPS   = 9;
    localparam int WIN_CENTER = 4;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Register map (word index)
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Input kinds
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [PIXEL_BITS-1:0]      t_chan;
    typedef logic [PIX_BITS-1:0]        t_pixel;
    typedef logic [COL_BITS-1:0]        t_col;
    typedef logic signed [OUT_BITS-1:0] t_result;

    // Write request from the front end to the line buffer
    typedef struct packed {
        logic   en;
        t_col   addr;
        t_pixel pix;
    } t_wr_req;

    // Per-transaction control that travels alongside the lanes
    typedef struct packed {
        logic emit;
        logic interior;
        logic frame_end;
    } t_ctl;

endpackage

`default_nettype wire

[hdl/rgb_sharpen_3x3.sv]
`default_nettype none

// 3x3 Laplacian sharpen of an RGB pixel stream in raster order. Each channel of
// an interior pixel becomes c + floor((k*(8c - S) + 1024) / 2048), with k the
// Q4.8 gain and S the sum of the eight neighbors; border pixels pass unchanged.
// One transaction is taken per clock while o_s_tready is high: the line buffer
// has one read and one write per row store each cycle and the three channel
// lanes are fully pipelined, so the block sustains one input transaction per
// cycle unless the result queue stalls it. A result follows the transaction
// that releases it, one row and one column behind the pixel it belongs to.
// After the last pixel of a frame, send W+1 flush transactions (tuser = 1) to
// drain the pending results; the next frame may instead follow directly and
// push them out. s_tdata holds red, green, blue from bit 0 up; m_tdata holds
// red, green, blue as 14-bit signed values from bit 0 up, and m_tlast marks the
// last pixel of a frame. Registers (APB, byte address): 0x0 gain, 0x4 frame
// width, 0x8 frame height; change them only while the block is idle.

module rgb_sharpen_3x3
    import rsh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  wire logic        i_s_tuser,   // command
    // output stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // red_out[13:0], green_out[27:14], blue_out[41:28]
    output logic             o_m_tlast,   // frame_end
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [GAIN_BITS-1:0] r_gain;
    logic [DIM_BITS-1:0]  r_width;
    logic [DIM_BITS-1:0]  r_height;
    logic                 w_cfg_wr;

    // Position and pending state
    t_col                r_in_col;
    t_col                r_in_row;
    t_col                r_out_col;
    t_col                r_out_row;
    logic [DIM_BITS-1:0] r_pending;
    t_col                n_in_col;
    t_col                n_in_row;
    t_col                n_out_col;
    t_col                n_out_row;
    logic [DIM_BITS-1:0] n_pending;

    logic [DIM_BITS-1:0] w_w;
    logic [DIM_BITS-1:0] w_h;
    t_col                w_ic;
    t_col                w_ir;
    t_col                w_oc;
    t_col                w_or;
    logic [DIM_BITS:0]   w_ic_inc;
    logic [DIM_BITS:0]   w_ir_inc;
    logic [DIM_BITS:0]   w_oc_inc;
    logic [DIM_BITS:0]   w_or_inc;
    logic                w_full;
    logic                w_accept;
    logic                w_is_pix;
    logic                w_active;
    t_col                w_rd_addr;
    t_ctl                w_ctl;

    // Stage after acceptance
    t_wr_req r_wr;
    logic    r_s1_shift;
    logic    r_s1_flush;
    t_pixel  w_top;
    t_pixel  w_mid;
    t_pixel  w_new;

    // Window and control pipeline
    t_pixel r_win [WIN_TAPS];
    t_ctl   r_p1;
    t_ctl   r_p2;
    t_ctl   r_p3;
    t_ctl   r_p4;

    t_chan   w_lane_win [NUM_LANES][WIN_TAPS];
    t_result w_lane_res [NUM_LANES];

    logic [FIFO_AW:0] w_fifo_count;
    logic [2:0]       w_inflight;

    // -------------------------------------------------------------------------
    // Configuration port
    // -------------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_BITS'(256);
            r_width  <= DIM_BITS'(640);
            r_height <= DIM_BITS'(480);
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_GAIN:   r_gain   <= pwdata[GAIN_BITS-1:0];
                REG_WIDTH:  r_width  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GAIN:   prdata = {{(32-GAIN_BITS){1'b0}}, r_gain};
            REG_WIDTH:  prdata = {{(32-DIM_BITS){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-DIM_BITS){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    // -------------------------------------------------------------------------
    // Front end: positions, pending count, line buffer address
    // -------------------------------------------------------------------------
    assign w_w = (r_width < DIM_BITS'(3)) ? DIM_BITS'(3)
               : (r_width > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS) : r_width;
    assign w_h = (r_height < DIM_BITS'(3)) ? DIM_BITS'(3)
               : (r_height > DIM_BITS'(ROW_LIMIT)) ? DIM_BITS'(ROW_LIMIT) : r_height;

    // Wrap positions that fall outside the current frame size
    assign w_ic = ({1'b0, r_in_col}  >= w_w) ? '0 : r_in_col;
    assign w_ir = ({1'b0, r_in_row}  >= w_h) ? '0 : r_in_row;
    assign w_oc = ({1'b0, r_out_col} >= w_w) ? '0 : r_out_col;
    assign w_or = ({1'b0, r_out_row} >= w_h) ? '0 : r_out_row;

    assign w_ic_inc = (DIM_BITS+1)'(w_ic) + 1'b1;
    assign w_ir_inc = (DIM_BITS+1)'(w_ir) + 1'b1;
    assign w_oc_inc = (DIM_BITS+1)'(w_oc) + 1'b1;
    assign w_or_inc = (DIM_BITS+1)'(w_or) + 1'b1;

    assign w_full   = {1'b0, r_pending} >= ({1'b0, w_w} + 1'b1);
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_is_pix = (i_s_tuser == CMD_PIXEL);
    // A flush with nothing pending is a no-op
    assign w_active = w_is_pix || (r_pending != '0);

    assign w_rd_addr = w_is_pix ? w_ic
                     : ((w_oc_inc >= {1'b0, w_w}) ? '0 : w_oc_inc[COL_BITS-1:0]);

    always_comb begin
        n_in_col  = w_ic;
        n_in_row  = w_ir;
        n_out_col = w_oc;
        n_out_row = w_or;
        n_pending = r_pending;

        w_ctl.emit      = w_is_pix ? w_full : w_active;
        w_ctl.interior  = (w_or != '0) && ((DIM_BITS+1)'(w_or) + 2'd2 <= {1'b0, w_h}) &&
                          (w_oc != '0) && ((DIM_BITS+1)'(w_oc) + 2'd2 <= {1'b0, w_w});
        w_ctl.frame_end = (w_or_inc == {1'b0, w_h}) && (w_oc_inc == {1'b0, w_w});

        // Advance the input position on a pixel
        if (w_is_pix) begin
            if (w_ic_inc >= {1'b0, w_w}) begin
                n_in_col = '0;
                n_in_row = (w_ir_inc >= {1'b0, w_h}) ? '0 : w_ir_inc[COL_BITS-1:0];
            end else begin
                n_in_col = w_ic_inc[COL_BITS-1:0];
            end
        end

        // Advance the output position on every result
        if (w_ctl.emit) begin
            if (w_oc_inc >= {1'b0, w_w}) begin
                n_out_col = '0;
                n_out_row = (w_or_inc >= {1'b0, w_h}) ? '0 : w_or_inc[COL_BITS-1:0];
            end else begin
                n_out_col = w_oc_inc[COL_BITS-1:0];
            end
        end

        // Track results still owed
        if (w_is_pix) begin
            n_pending = w_full ? (w_w + 1'b1) : (r_pending + 1'b1);
        end else if (w_active) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
        end else if (w_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pending <= n_pending;
        end
    end

    // Register the transaction while the line buffer reads
    always_ff @(posedge i_clk) begin
        r_wr.addr <= w_rd_addr;
        r_wr.pix  <= i_s_tdata;
        if (!i_rst_n) begin
            r_wr.en    <= 1'b0;
            r_s1_shift <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            r_wr.en    <= w_accept && w_is_pix;
            r_s1_shift <= w_accept && w_active;
            r_s1_flush <= !w_is_pix;
        end
    end

    rsh_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .i_wr      (r_wr),
        .o_top     (w_top),
        .o_mid     (w_mid)
    );

    // -------------------------------------------------------------------------
    // 3x3 window: shift in one column per active transaction
    // -------------------------------------------------------------------------
    assign w_new = r_s1_flush ? '0 : r_wr.pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= w_top;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= w_mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= w_new;
        end
    end

    // Control travels beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= '0;
            r_p2 <= '0;
            r_p3 <= '0;
            r_p4 <= '0;
        end else begin
            r_p1 <= w_accept ? w_ctl : '0;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            r_p4 <= r_p3;
        end
    end

    // -------------------------------------------------------------------------
    // Channel lanes
    // -------------------------------------------------------------------------
    for (genvar ch = 0; ch < NUM_LANES; ch++) begin : g_lane
        for (genvar t = 0; t < WIN_TAPS; t++) begin : g_tap
            assign w_lane_win[ch][t] = r_win[t][ch*PIXEL_BITS +: PIXEL_BITS];
        end

        rsh_lane u_lane (
            .i_clk      (i_clk),
            .i_win      (w_lane_win[ch]),
            .i_interior (r_p2.interior),
            .i_gain     (r_gain),
            .o_result   (w_lane_res[ch])
        );
    end

    // -------------------------------------------------------------------------
    // Merge into the result queue; stall input only when it could overflow
    // -------------------------------------------------------------------------
    rsh_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p4.emit),
        .i_red   (w_lane_res[0]),
        .i_green (w_lane_res[1]),
        .i_blue  (w_lane_res[2]),
        .i_last  (r_p4.frame_end),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast),
        .o_count (w_fifo_count)
    );

    assign w_inflight = 3'(r_p1.emit) + 3'(r_p2.emit) + 3'(r_p3.emit) + 3'(r_p4.emit);
    assign o_s_tready = (5'(w_fifo_count) + 5'(w_inflight) + 5'd1) <= 5'(FIFO_DEPTH);

    // -------------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p4.emit |-> (w_fifo_count < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (5'(w_fifo_count) + 5'(w_inflight)) <= 5'(FIFO_DEPTH))
        else $error("results in flight exceed queue space");

    a_pixel_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_tuser == CMD_PIXEL)) |=> (r_s1_shift && r_wr.en))
        else $error("accepted pixel did not enter the window");

    a_idle_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_tuser == CMD_FLUSH) && (r_pending == '0))
            |=> (!r_p1.emit && !r_s1_shift && $stable(r_pending)))
        else $error("flush with nothing pending changed state");

endmodule

`default_nettype wire

[hdl/rsh_line_buf.sv]
`default_nettype none

module rsh_line_buf
    import rsh_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rd_en,
    input  wire t_col    i_rd_addr,
    input  wire t_wr_req i_wr,
    output t_pixel       o_top,
    output t_pixel       o_mid
);

    t_pixel r_mem_top [MAX_COLS];
    t_pixel r_mem_mid [MAX_COLS];
    t_pixel r_top;
    t_pixel r_mid;
    logic   w_fwd;

    // A read that hits the row being written this cycle takes the new data
    assign w_fwd = i_wr.en && (i_wr.addr == i_rd_addr);

    // Move the middle row up and store the new pixel
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem_top[i_wr.addr] <= r_mid;
            r_mem_mid[i_wr.addr] <= i_wr.pix;
        end
    end

    // Registered read of both rows
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (w_fwd) begin
                r_top <= r_mid;
                r_mid <= i_wr.pix;
            end else begin
                r_top <= r_mem_top[i_rd_addr];
                r_mid <= r_mem_mid[i_rd_addr];
            end
        end
    end

    assign o_top = r_top;
    assign o_mid = r_mid;

endmodule

`default_nettype wire

[hdl/rsh_lane.sv]
`default_nettype none

module rsh_lane
    import rsh_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_chan                i_win [WIN_TAPS],
    input  wire logic                 i_interior,
    input  wire logic [GAIN_BITS-1:0] i_gain,
    output t_result                   o_result
);

    logic        [PIXEL_BITS+2:0] w_sum;
    logic signed [PIXEL_BITS+3:0] w_diff;
    logic signed [PIXEL_BITS+3:0] r_diff;
    t_chan                        r_c1;
    logic                         r_int1;

    logic signed [24:0] w_prod;
    logic signed [24:0] r_prod;
    t_chan              r_c2;
    logic               r_int2;

    logic signed [25:0] w_round;
    logic signed [14:0] w_quot;
    logic signed [15:0] w_val;

    // Sum the eight neighbors and form 8c - S
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            if (i != WIN_CENTER) begin
                w_sum = w_sum + {3'b000, i_win[i]};
            end
        end
        w_diff = $signed({1'b0, i_win[WIN_CENTER], 3'b000}) - $signed({1'b0, w_sum});
    end

    always_ff @(posedge i_clk) begin
        r_diff <= w_diff;
        r_c1   <= i_win[WIN_CENTER];
        r_int1 <= i_interior;
    end

    // Scale by the gain
    assign w_prod = $signed({1'b0, i_gain}) * r_diff;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_c2   <= r_c1;
        r_int2 <= r_int1;
    end

    // Round half up, floor by 2048, add the center back
    assign w_round  = 26'(r_prod) + 26'sd1024;
    assign w_quot   = w_round[25:11];
    assign w_val    = {w_quot[14], w_quot} + $signed({8'b0, r_c2});
    assign o_result = r_int2 ? w_val[OUT_BITS-1:0]
                             : t_result'({{(OUT_BITS-PIXEL_BITS){1'b0}}, r_c2});

endmodule

`default_nettype wire

[hdl/rsh_out_fifo.sv]
`default_nettype none

module rsh_out_fifo
    import rsh_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire t_result                     i_red,
    input  wire t_result                     i_green,
    input  wire t_result                     i_blue,
    input  wire logic                        i_last,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [47:0]                      o_data,
    output logic                             o_last,
    output logic [FIFO_AW:0]                 o_count
);

    localparam int ENTRY_BITS = 3 * OUT_BITS + 1;

    logic [ENTRY_BITS-1:0] r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [FIFO_AW:0]      r_count;
    logic                  w_pop;
    logic [ENTRY_BITS-1:0] w_head;

    assign w_pop = o_valid && i_ready;

    // Merge the three lanes and the frame marker into one entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= {i_last, i_blue, i_green, i_red};
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(w_pop);
        end
    end

    assign w_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_data  = {{(48 - 3*OUT_BITS){1'b0}}, w_head[3*OUT_BITS-1:0]};
    assign o_last  = w_head[ENTRY_BITS-1];
    assign o_count = r_count;

endmodule

`default_nettype wire
